// ===== rtl/core/rmq_pkg.sv =====
`timescale 1ns / 1ps

package rmq_pkg;

  // Field format
  localparam int DataWidth = 16;
  localparam int FracBits  = DataWidth - 2;

  // Internal widths
  localparam int SumW  = DataWidth + 3;      // signed trace sums
  localparam int PivW  = DataWidth + 1;      // largest sum, always positive
  localparam int DiffW = DataWidth + 1;      // signed off-diagonal terms
  localparam int RadW  = 2 * DataWidth;      // radicand, padded to even width
  localparam int RootW = DataWidth;          // pivot root
  localparam int DvdW  = 2 * DataWidth - 1;  // rounded dividend
  localparam int QuoW  = DataWidth + 1;      // quotient magnitude

  // Pipeline depth: front stage, one stage per root bit, one per quotient bit, output
  localparam int Latency = 1 + RootW + QuoW + 1;

  typedef enum logic [1:0] {
    PIV_W,
    PIV_X,
    PIV_Y,
    PIV_Z
  } pivot_e;

  // Words riding along with the root pipeline
  typedef struct packed {
    pivot_e                   piv;
    logic signed [DiffW-1:0]  d0;
    logic signed [DiffW-1:0]  d1;
    logic signed [DiffW-1:0]  d2;
  } side_t;

  typedef struct packed {
    logic [RootW+1:0] rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [DvdW-1:0]  dvd;
    logic [QuoW-1:0]  quo;
  } div_t;

  // One bit of the digit-by-digit square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [RootW+1:0] rem2;
    logic [RootW+1:0] trial;
    sqrt_t            r;
    rem2  = {s.rem[RootW-1:0], s.rad[RadW-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[RadW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // One bit of restoring division by m
  function automatic div_t div_step(div_t s, logic [RootW-1:0] m);
    logic [RootW:0] rem2;
    div_t           r;
    rem2  = {s.rem, s.dvd[DvdW-1]};
    r.dvd = {s.dvd[DvdW-2:0], 1'b0};
    if (rem2 >= {1'b0, m}) begin
      r.rem = RootW'(rem2 - {1'b0, m});
      r.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = rem2[RootW-1:0];
      r.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rmq_front.sv =====
`timescale 1ns / 1ps

module rmq_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r00_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r01_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r02_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r10_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r11_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r12_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r20_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r21_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r22_i,
  output logic                                  valid_o,
  output logic        [rmq_pkg::PivW-1:0]       s_o,
  output rmq_pkg::side_t                        side_o
);

  localparam int SW = rmq_pkg::SumW;
  localparam int DW = rmq_pkg::DiffW;
  localparam logic signed [SW-1:0] One = SW'(1) <<< rmq_pkg::FracBits;

  logic signed [SW-1:0] a00, a11, a22;
  logic signed [SW-1:0] sw, sx, sy, sz, sbest;
  logic signed [DW-1:0] dwx, dwy, dwz, dxy, dxz, dyz;
  rmq_pkg::pivot_e      piv;
  rmq_pkg::side_t       side_d, side_q;
  logic [rmq_pkg::PivW-1:0] s_d, s_q;
  logic                 valid_q;

  // Trace sums and off-diagonal terms
  always_comb begin
    a00 = SW'(r00_i);
    a11 = SW'(r11_i);
    a22 = SW'(r22_i);
    sw  = One + a00 + a11 + a22;
    sx  = One + a00 - a11 - a22;
    sy  = One - a00 + a11 - a22;
    sz  = One - a00 - a11 + a22;
    dwx = DW'(r21_i) - DW'(r12_i);
    dwy = DW'(r02_i) - DW'(r20_i);
    dwz = DW'(r10_i) - DW'(r01_i);
    dxy = DW'(r10_i) + DW'(r01_i);
    dxz = DW'(r02_i) + DW'(r20_i);
    dyz = DW'(r21_i) + DW'(r12_i);
  end

  // Pick the largest, earlier candidate wins a tie
  always_comb begin
    piv   = rmq_pkg::PIV_W;
    sbest = sw;
    if (sbest < sx) begin
      piv   = rmq_pkg::PIV_X;
      sbest = sx;
    end
    if (sbest < sy) begin
      piv   = rmq_pkg::PIV_Y;
      sbest = sy;
    end
    if (sbest < sz) begin
      piv   = rmq_pkg::PIV_Z;
      sbest = sz;
    end
    s_d        = sbest[rmq_pkg::PivW-1:0];
    side_d.piv = piv;
    // lanes: the three non-pivot components in order x, y, z, w
    case (piv)
      rmq_pkg::PIV_W: begin
        side_d.d0 = dwx;
        side_d.d1 = dwy;
        side_d.d2 = dwz;
      end
      rmq_pkg::PIV_X: begin
        side_d.d0 = dxy;
        side_d.d1 = dxz;
        side_d.d2 = dwx;
      end
      rmq_pkg::PIV_Y: begin
        side_d.d0 = dxy;
        side_d.d1 = dyz;
        side_d.d2 = dwy;
      end
      default: begin
        side_d.d0 = dxz;
        side_d.d1 = dyz;
        side_d.d2 = dwz;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
`timescale 1ns / 1ps

module rmq_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [rmq_pkg::PivW-1:0]        s_i,
  input  rmq_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic [rmq_pkg::RootW-1:0]       m_o,
  output rmq_pkg::side_t                  side_o
);

  localparam int N = rmq_pkg::RootW;

  rmq_pkg::sqrt_t init;
  rmq_pkg::sqrt_t st_q   [N];
  rmq_pkg::side_t side_q [N];
  logic [N-1:0]   valid_q;

  // Radicand is the sum scaled by 2^F
  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.rad  = rmq_pkg::RadW'({s_i, rmq_pkg::FracBits'(0)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[N-2:0], valid_i};
    end
  end

  // One root bit per stage
  always_ff @(posedge clk_i) begin
    st_q[0]   <= rmq_pkg::sqrt_step(init);
    side_q[0] <= side_i;
    for (int k = 1; k < N; k++) begin
      st_q[k]   <= rmq_pkg::sqrt_step(st_q[k-1]);
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = valid_q[N-1];
  assign m_o     = st_q[N-1].root;
  assign side_o  = side_q[N-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
`timescale 1ns / 1ps

module rmq_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [rmq_pkg::RootW-1:0]       m_i,
  input  rmq_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic [rmq_pkg::RootW-1:0]       m_o,
  output rmq_pkg::pivot_e                 piv_o,
  output logic [2:0]                      neg_o,
  output logic [rmq_pkg::QuoW-1:0]        quo0_o,
  output logic [rmq_pkg::QuoW-1:0]        quo1_o,
  output logic [rmq_pkg::QuoW-1:0]        quo2_o
);

  localparam int N  = rmq_pkg::QuoW;
  localparam int DW = rmq_pkg::DiffW;
  localparam int VW = rmq_pkg::DvdW;

  logic signed [DW-1:0] d [3];
  rmq_pkg::div_t        init [3];
  rmq_pkg::div_t        ln_q [N][3];
  logic [rmq_pkg::RootW-1:0] m_q [N];
  rmq_pkg::pivot_e      piv_q [N];
  logic [2:0]           neg_q [N];
  logic [2:0]           neg_in;
  logic [N-1:0]         valid_q;

  // Dividend: |d| * 2^(F-1) plus half the divisor for rounding
  always_comb begin
    logic [DW-1:0] a;
    logic [VW-1:0] num;
    d[0] = side_i.d0;
    d[1] = side_i.d1;
    d[2] = side_i.d2;
    for (int k = 0; k < 3; k++) begin
      neg_in[k]    = d[k][DW-1];
      a            = neg_in[k] ? DW'(-d[k]) : DW'(d[k]);
      num          = (VW'(a) << (rmq_pkg::FracBits - 1)) + VW'(m_i >> 1);
      // bits above the quotient width start as remainder, always below m
      init[k].rem  = rmq_pkg::RootW'(num >> N);
      init[k].quo  = '0;
      init[k].dvd  = num << (VW - N);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[N-2:0], valid_i};
    end
  end

  // One quotient bit per stage in each lane
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      ln_q[0][j] <= rmq_pkg::div_step(init[j], m_i);
    end
    m_q[0]   <= m_i;
    piv_q[0] <= side_i.piv;
    neg_q[0] <= neg_in;
    for (int k = 1; k < N; k++) begin
      for (int j = 0; j < 3; j++) begin
        ln_q[k][j] <= rmq_pkg::div_step(ln_q[k-1][j], m_q[k-1]);
      end
      m_q[k]   <= m_q[k-1];
      piv_q[k] <= piv_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
  end

  assign valid_o = valid_q[N-1];
  assign m_o     = m_q[N-1];
  assign piv_o   = piv_q[N-1];
  assign neg_o   = neg_q[N-1];
  assign quo0_o  = ln_q[N-1][0].quo;
  assign quo1_o  = ln_q[N-1][1].quo;
  assign quo2_o  = ln_q[N-1][2].quo;

endmodule

// ===== rtl/core/rmq_back.sv =====
`timescale 1ns / 1ps

module rmq_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [rmq_pkg::RootW-1:0]             m_i,
  input  rmq_pkg::pivot_e                       piv_i,
  input  logic [2:0]                            neg_i,
  input  logic [rmq_pkg::QuoW-1:0]              quo0_i,
  input  logic [rmq_pkg::QuoW-1:0]              quo1_i,
  input  logic [rmq_pkg::QuoW-1:0]              quo2_i,
  output logic                                  valid_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qx_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qy_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qz_o
);

  localparam int W  = rmq_pkg::DataWidth;
  localparam int QW = rmq_pkg::QuoW;
  localparam logic [QW-1:0] MaxPos = QW'((1 << (W - 1)) - 1);
  localparam logic [QW-1:0] MaxNeg = QW'(1 << (W - 1));

  logic [QW-1:0] pmag;
  logic [QW-1:0] mag [3];
  logic [2:0]    ng;
  logic          flip;
  logic [W-1:0]  res [3];
  logic [W-1:0]  qx_q, qy_q, qz_q;
  logic          valid_q;

  // Route pivot root and lane quotients to x, y, z
  always_comb begin
    logic [QW-1:0] tmp;
    logic          n;
    pmag = QW'((QW'(m_i) + QW'(1)) >> 1);
    flip = 1'b0;
    case (piv_i)
      rmq_pkg::PIV_W: begin
        mag[0] = quo0_i; mag[1] = quo1_i; mag[2] = quo2_i;
        ng     = neg_i;
      end
      rmq_pkg::PIV_X: begin
        mag[0] = pmag;   mag[1] = quo0_i; mag[2] = quo1_i;
        ng     = {neg_i[1], neg_i[0], 1'b0};
        flip   = neg_i[2];
      end
      rmq_pkg::PIV_Y: begin
        mag[0] = quo0_i; mag[1] = pmag;   mag[2] = quo1_i;
        ng     = {neg_i[1], 1'b0, neg_i[0]};
        flip   = neg_i[2];
      end
      default: begin
        mag[0] = quo0_i; mag[1] = quo1_i; mag[2] = pmag;
        ng     = {1'b0, neg_i[1], neg_i[0]};
        flip   = neg_i[2];
      end
    endcase
    // Negate when the lane sign and the sign of w differ, then saturate
    for (int k = 0; k < 3; k++) begin
      n = (ng[k] ^ flip) && (mag[k] != '0);
      if (n) begin
        tmp    = (mag[k] > MaxNeg) ? MaxNeg : mag[k];
        res[k] = W'(-tmp);
      end else begin
        tmp    = (mag[k] > MaxPos) ? MaxPos : mag[k];
        res[k] = tmp[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= res[0];
    qy_q <= res[1];
    qz_q <= res[2];
  end

  assign valid_o = valid_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign qz_o    = qz_q;

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

// Rotation matrix to quaternion vector part, Q2.14 in and out.
// Command channel: a matrix word (r00..r22) is taken on a rising edge with
// start high and busy low. busy stays low, so a new matrix may be started
// in every cycle.
// Result channel: qx, qy, qz appear for exactly one cycle with done_o high,
// in start order, one result per matrix. The receiver cannot stall and must
// take each word in the cycle it is shown.
// Pipeline from start to done_o: one stage for trace sums and pivot choice,
// one stage per root bit of the square root pipeline, one stage per quotient
// bit of the three divider lanes, and one output stage with negation and
// saturation.
// Throughput: one matrix per cycle.
// Reset (rst_ni low, asynchronous) drops every word in flight; done_o
// stays low until a matrix started after reset reaches the output.

module rotation_matrix_to_quaternion (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r00_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r01_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r02_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r10_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r11_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r12_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r20_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r21_i,
  input  logic signed [rmq_pkg::DataWidth-1:0]  r22_i,
  output logic                                  done_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qx_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qy_o,
  output logic signed [rmq_pkg::DataWidth-1:0]  qz_o
);

  logic                           f_valid, s_valid, d_valid;
  logic [rmq_pkg::PivW-1:0]       f_s;
  rmq_pkg::side_t                 f_side, s_side;
  logic [rmq_pkg::RootW-1:0]      s_m, d_m;
  rmq_pkg::pivot_e                d_piv;
  logic [2:0]                     d_neg;
  logic [rmq_pkg::QuoW-1:0]       d_q0, d_q1, d_q2;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .r00_i   (r00_i),
    .r01_i   (r01_i),
    .r02_i   (r02_i),
    .r10_i   (r10_i),
    .r11_i   (r11_i),
    .r12_i   (r12_i),
    .r20_i   (r20_i),
    .r21_i   (r21_i),
    .r22_i   (r22_i),
    .valid_o (f_valid),
    .s_o     (f_s),
    .side_o  (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .s_i     (f_s),
    .side_i  (f_side),
    .valid_o (s_valid),
    .m_o     (s_m),
    .side_o  (s_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .m_i     (s_m),
    .side_i  (s_side),
    .valid_o (d_valid),
    .m_o     (d_m),
    .piv_o   (d_piv),
    .neg_o   (d_neg),
    .quo0_o  (d_q0),
    .quo1_o  (d_q1),
    .quo2_o  (d_q2)
  );

  rmq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .m_i     (d_m),
    .piv_i   (d_piv),
    .neg_i   (d_neg),
    .quo0_i  (d_q0),
    .quo1_i  (d_q1),
    .quo2_i  (d_q2),
    .valid_o (done_o),
    .qx_o    (qx_o),
    .qy_o    (qy_o),
    .qz_o    (qz_o)
  );

`ifndef NO_ASSERTIONS
  // The root of the largest candidate is never below one
  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid |-> s_m[rmq_pkg::RootW-1] || s_m[rmq_pkg::FracBits])
    else $error("pivot root below one");

  // Every start shows up at the output after the pipeline depth
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(rmq_pkg::Latency) done_o)
    else $error("result lost");

  // No result without a start the pipeline depth earlier
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, rmq_pkg::Latency))
    else $error("result invented");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int W = rmq_pkg::DataWidth;
  localparam int F = rmq_pkg::FracBits;

  typedef logic signed [W-1:0] entry_t;

  typedef struct {
    entry_t qx;
    entry_t qy;
    entry_t qz;
  } quat_t;

  // Predicts the quaternion vector part and holds results still in flight
  class quat_scoreboard;
    quat_t pending[$];
    int    errors = 0;

    static function longint isqrt(longint v);
      longint res;
      longint b;
      res = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >>> 1) + b;
        end else begin
          res = res >>> 1;
        end
        b = b >>> 2;
      end
      return res;
    endfunction

    static function longint div_round(longint d, longint m, output bit neg);
      longint a;
      a = d < 0 ? -d : d;
      neg = d < 0;
      return ((a <<< (F - 1)) + (m >>> 1)) / m;
    endfunction

    static function entry_t sat(bit neg, longint mag);
      longint maxpos;
      maxpos = (64'sd1 <<< (W - 1)) - 1;
      if (neg) begin
        if (mag > maxpos + 1) mag = maxpos + 1;
        return entry_t'(-mag);
      end
      if (mag > maxpos) mag = maxpos;
      return entry_t'(mag);
    endfunction

    function void note_matrix(entry_t r[9]);
      longint e[9];
      longint s[4];
      longint dwx, dwy, dwz, dxy, dxz, dyz, m;
      longint mag[4];
      bit     neg[4];
      rmq_pkg::pivot_e piv;
      entry_t o[3];
      bit     n;
      quat_t  q;
      for (int i = 0; i < 9; i++) e[i] = r[i];
      s[0] = (64'sd1 <<< F) + e[0] + e[4] + e[8];
      s[1] = (64'sd1 <<< F) + e[0] - e[4] - e[8];
      s[2] = (64'sd1 <<< F) - e[0] + e[4] - e[8];
      s[3] = (64'sd1 <<< F) - e[0] - e[4] + e[8];
      piv = rmq_pkg::PIV_W;
      for (int k = 1; k < 4; k++) if (s[piv] < s[k]) piv = rmq_pkg::pivot_e'(k);
      dwx = e[7] - e[5];
      dwy = e[2] - e[6];
      dwz = e[3] - e[1];
      dxy = e[3] + e[1];
      dxz = e[2] + e[6];
      dyz = e[7] + e[5];
      m = isqrt(s[piv] <<< F);
      // index 0..2 = x,y,z, 3 = w
      case (piv)
        rmq_pkg::PIV_W: begin
          mag[3] = (m + 1) >>> 1; neg[3] = 0;
          mag[0] = div_round(dwx, m, neg[0]);
          mag[1] = div_round(dwy, m, neg[1]);
          mag[2] = div_round(dwz, m, neg[2]);
        end
        rmq_pkg::PIV_X: begin
          mag[0] = (m + 1) >>> 1; neg[0] = 0;
          mag[3] = div_round(dwx, m, neg[3]);
          mag[1] = div_round(dxy, m, neg[1]);
          mag[2] = div_round(dxz, m, neg[2]);
        end
        rmq_pkg::PIV_Y: begin
          mag[1] = (m + 1) >>> 1; neg[1] = 0;
          mag[3] = div_round(dwy, m, neg[3]);
          mag[0] = div_round(dxy, m, neg[0]);
          mag[2] = div_round(dyz, m, neg[2]);
        end
        default: begin
          mag[2] = (m + 1) >>> 1; neg[2] = 0;
          mag[3] = div_round(dwz, m, neg[3]);
          mag[0] = div_round(dxz, m, neg[0]);
          mag[1] = div_round(dyz, m, neg[1]);
        end
      endcase
      // negative w flips the whole quaternion; zero stays positive
      for (int k = 0; k < 3; k++) begin
        n = neg[3] ? !neg[k] : neg[k];
        if (mag[k] == 0) n = 0;
        o[k] = sat(n, mag[k]);
      end
      q.qx = o[0];
      q.qy = o[1];
      q.qz = o[2];
      pending = {pending, q};
    endfunction

    function void check_result(entry_t qx, entry_t qy, entry_t qz);
      quat_t q;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: %0d %0d %0d", qx, qy, qz);
        errors++;
        return;
      end
      q = pending.pop_front();
      if (q.qx !== qx) begin
        $error("qx expected %0d actual %0d", q.qx, qx); errors++;
      end
      if (q.qy !== qy) begin
        $error("qy expected %0d actual %0d", q.qy, qy); errors++;
      end
      if (q.qz !== qz) begin
        $error("qz expected %0d actual %0d", q.qz, qz); errors++;
      end
    endfunction
  endclass

  logic   clk_i = 0;
  logic   rst_ni = 0;
  logic   start = 0;
  logic   busy;
  entry_t r00_i = 0, r01_i = 0, r02_i = 0, r10_i = 0, r11_i = 0;
  entry_t r12_i = 0, r20_i = 0, r21_i = 0, r22_i = 0;
  logic   done_o;
  entry_t qx_o, qy_o, qz_o;

  quat_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  rotation_matrix_to_quaternion DUT (.*);

  // Result side: the block cannot be stalled, so just sample every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(qx_o, qy_o, qz_o);
  end

  // Sends one matrix word, holding start until the handshake completes
  task automatic send_matrix(entry_t r[9]);
    r00_i <= r[0]; r01_i <= r[1]; r02_i <= r[2];
    r10_i <= r[3]; r11_i <= r[4]; r12_i <= r[5];
    r20_i <= r[6]; r21_i <= r[7]; r22_i <= r[8];
    start <= 1;
    do @(posedge clk_i); while (busy);
    sb.note_matrix(r);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Rotation about a single axis with a random angle, optionally perturbed
  function automatic void axis_rotation(output entry_t r[9], input int axis, bit noisy);
    real a, c, s;
    int  i0, i1, i2;
    a = $urandom_range(0, 62831) / 10000.0;
    c = $cos(a) * 16384.0;
    s = $sin(a) * 16384.0;
    for (int k = 0; k < 9; k++) r[k] = 0;
    i0 = axis; i1 = (axis + 1) % 3; i2 = (axis + 2) % 3;
    r[i0 * 3 + i0] = 16384;
    r[i1 * 3 + i1] = entry_t'($rtoi(c));
    r[i2 * 3 + i2] = entry_t'($rtoi(c));
    r[i1 * 3 + i2] = entry_t'(-$rtoi(s));
    r[i2 * 3 + i1] = entry_t'($rtoi(s));
    if (noisy) for (int k = 0; k < 9; k++) r[k] = r[k] + entry_t'($urandom_range(0, 64) - 32);
  endfunction

  initial begin
    entry_t r[9];
    entry_t ext[4];
    ext = '{entry_t'(16'sh7fff), entry_t'(-16'sh8000), 0, entry_t'(-1)};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: identity, pivot on each of w/x/y/z, ties, extremes
    r = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    send_matrix(r);
    r = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    send_matrix(r);
    r = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    send_matrix(r);
    r = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    send_matrix(r);
    r = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(r);
    // w slightly negative with a tiny numerator
    r = '{16384, 0, 0, 0, -16384, 1, 0, 0, -16384};
    send_matrix(r);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 9; j++) r[j] = ext[k];
      send_matrix(r);
      for (int j = 0; j < 9; j++) r[j] = ext[(j + k) % 4];
      send_matrix(r);
    end
    r = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_matrix(r);
    r = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(r);
    for (int a = 0; a < 3; a++) begin
      axis_rotation(r, a, 0);
      send_matrix(r);
    end

    // Random: mostly rotations, some with noise, and some raw random patterns
    for (int i = 0; i < 2000; i++) begin
      if ($urandom_range(0, 2) == 0)
        for (int j = 0; j < 9; j++) r[j] = entry_t'($urandom());
      else
        axis_rotation(r, $urandom_range(0, 2), $urandom_range(0, 1));
      send_matrix(r);
      idle_gap();
      // hold off until the pipeline has drained once midway
      if (i == 1000) begin
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (rmq_pkg::Latency + 5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rmq_back.sv
rtl/core/rotation_matrix_to_quaternion.sv
dv/testbench.sv
